/* src/brst_pkg.sv */
// Package: constants, types and helper functions for the bucketed range sum table.
package brst_pkg;

   localparam int INDEX_W      = 10;
   localparam int DELTA_W      = 32;
   localparam int ELEM_W       = 32;
   localparam int TOTAL_W      = 64;
   localparam int ARRAY_DEPTH  = 1024;
   localparam int BUCKET_BITS  = 5;
   localparam int BUCKET_SIZE  = 1 << BUCKET_BITS;
   localparam int BUCKET_COUNT = (ARRAY_DEPTH + BUCKET_SIZE - 1) / BUCKET_SIZE;
   localparam int ADDR_W       = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int CMP_W        = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ARRAY_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BKT_MASK  = ADDR_W'(BUCKET_SIZE - 1);

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ELEM,
      ACC_BUCKET,
      ACC_UPD_ELEM,
      ACC_UPD_BUCKET
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic              load_delta;
      logic              load_out;
      logic              elem_we;
      logic              bkt_we;
      logic              wr_zero;
      logic [ADDR_W-1:0] elem_addr;
      logic [BKT_W-1:0]  bkt_addr;
   } ctl_type;

   function automatic logic [BKT_W-1:0] bucket_of(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] sh;
      sh = addr >> BUCKET_BITS;
      return sh[BKT_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] bucket_first(input logic [BKT_W-1:0] b);
      logic [ADDR_W-1:0] w;
      w = ADDR_W'(b);
      return w << BUCKET_BITS;
   endfunction

   function automatic logic [ADDR_W-1:0] bucket_last(input logic [BKT_W-1:0] b);
      return bucket_first(b) | BKT_MASK;
   endfunction

endpackage

/* src/brst_channels_if.sv */
// Interfaces: request and response channels with valid/ready handshakes.
interface brst_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic        [brst_pkg::INDEX_W-1:0] index;
   logic signed [brst_pkg::DELTA_W-1:0] delta;
   logic        [brst_pkg::INDEX_W-1:0] range_low;
   logic        [brst_pkg::INDEX_W-1:0] range_high;

   modport source(output valid, op, index, delta, range_low, range_high, input ready);
   modport sink(input valid, op, index, delta, range_low, range_high, output ready);
endinterface

interface brst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [brst_pkg::TOTAL_W-1:0] range_total;

   modport source(output valid, range_total, input ready);
   modport sink(input valid, range_total, output ready);
endinterface

/* src/brst_ram.sv */
// Generic single-address RAM with registered read data.
module brst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rdata = rd_data_ff;

endmodule

/* src/brst_accum.sv */
// Shared 64-bit adder with the running accumulator, delta and result registers.
module brst_accum (
   input  logic                                clock,
   input  brst_pkg::ctl_type                   ctl,
   input  logic        [brst_pkg::DELTA_W-1:0] delta,
   input  logic        [brst_pkg::ELEM_W-1:0]  elem_rd,
   input  logic        [brst_pkg::TOTAL_W-1:0] bkt_rd,
   output logic        [brst_pkg::ELEM_W-1:0]  elem_wdata,
   output logic        [brst_pkg::TOTAL_W-1:0] bkt_wdata,
   output logic signed [brst_pkg::TOTAL_W-1:0] total
);

   localparam int EXT_W = brst_pkg::TOTAL_W - brst_pkg::ELEM_W;
   localparam int DEXT_W = brst_pkg::TOTAL_W - brst_pkg::DELTA_W;

   logic [brst_pkg::TOTAL_W-1:0] acc_ff, acc_in;
   logic [brst_pkg::DELTA_W-1:0] delta_ff;
   logic [brst_pkg::TOTAL_W-1:0] out_ff;
   logic [brst_pkg::TOTAL_W-1:0] elem_ext, delta_ext;
   logic [brst_pkg::TOTAL_W-1:0] op_a, op_b, sum;

   assign elem_ext  = {{EXT_W{elem_rd[brst_pkg::ELEM_W-1]}}, elem_rd};
   assign delta_ext = {{DEXT_W{delta_ff[brst_pkg::DELTA_W-1]}}, delta_ff};

   always_comb begin
      op_a   = acc_ff;
      op_b   = '0;
      acc_in = acc_ff;
      unique case (ctl.mode)
         brst_pkg::ACC_HOLD: begin
         end
         brst_pkg::ACC_CLEAR: begin
            acc_in = '0;
         end
         brst_pkg::ACC_ELEM: begin
            op_b   = elem_ext;
            acc_in = sum;
         end
         brst_pkg::ACC_BUCKET: begin
            op_b   = bkt_rd;
            acc_in = sum;
         end
         brst_pkg::ACC_UPD_ELEM: begin
            op_a = elem_ext;
            op_b = delta_ext;
         end
         brst_pkg::ACC_UPD_BUCKET: begin
            op_a = bkt_rd;
            op_b = delta_ext;
         end
         default: begin
         end
      endcase
   end

   assign sum = op_a + op_b;

   assign elem_wdata = ctl.wr_zero ? '0 : sum[brst_pkg::ELEM_W-1:0];
   assign bkt_wdata  = ctl.wr_zero ? '0 : sum;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.load_delta) begin
         delta_ff <= delta;
      end
      if (ctl.load_out) begin
         out_ff <= acc_ff;
      end
   end

   assign total = out_ff;

endmodule

/* src/brst_ctrl.sv */
// Sequencer: clearing pass, update steps and the fragment and bucket walk of a query.
module brst_ctrl (
   input  logic              clock,
   input  logic              reset,
   brst_req_if.sink          req,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output brst_pkg::ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_ELEM,
      ST_UPD_BUCKET,
      ST_FRAG_LOW,
      ST_FRAG_HIGH,
      ST_BUCKETS,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [brst_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [brst_pkg::ADDR_W-1:0]  last_ff, last_in;
   logic [brst_pkg::ADDR_W-1:0]  hi_ff, hi_in;
   logic [brst_pkg::BKT_W-1:0]   bptr_ff, bptr_in;
   logic [brst_pkg::BKT_W-1:0]   bh_ff, bh_in;
   logic                         same_ff, same_in;
   brst_pkg::mode_type           pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [brst_pkg::CMP_W-1:0]   idx_wide, lo_wide, hi_wide;
   logic [brst_pkg::ADDR_W-1:0]  hi_clamp, lo_addr, ptr_next;
   logic [brst_pkg::BKT_W-1:0]   b_low, b_high, bptr_next;
   logic                         in_table, reversed;

   assign idx_wide  = brst_pkg::CMP_W'(req.index);
   assign lo_wide   = brst_pkg::CMP_W'(req.range_low);
   assign hi_wide   = brst_pkg::CMP_W'(req.range_high);
   assign in_table  = idx_wide < brst_pkg::CMP_W'(brst_pkg::ARRAY_DEPTH);
   assign hi_clamp  = (hi_wide > brst_pkg::CMP_W'(brst_pkg::LAST_ADDR))
                      ? brst_pkg::LAST_ADDR : hi_wide[brst_pkg::ADDR_W-1:0];
   assign reversed  = lo_wide > brst_pkg::CMP_W'(hi_clamp);
   assign lo_addr   = lo_wide[brst_pkg::ADDR_W-1:0];
   assign b_low     = brst_pkg::bucket_of(lo_addr);
   assign b_high    = brst_pkg::bucket_of(hi_clamp);
   assign ptr_next  = ptr_ff + 1'b1;
   assign bptr_next = bptr_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      hi_in        = hi_ff;
      bptr_in      = bptr_ff;
      bh_in        = bh_ff;
      same_in      = same_ff;
      pend_in      = brst_pkg::ACC_HOLD;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req.ready    = 1'b0;

      ctl            = '0;
      ctl.mode       = pend_ff;
      ctl.elem_addr  = ptr_ff;
      ctl.bkt_addr   = bptr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ctl.wr_zero  = 1'b1;
            ctl.elem_we  = 1'b1;
            ctl.bkt_addr = ptr_ff[brst_pkg::BKT_W-1:0];
            ctl.bkt_we   = ({1'b0, ptr_ff} < (brst_pkg::ADDR_W + 1)'(brst_pkg::BUCKET_COUNT));
            ptr_in       = ptr_next;
            if (ptr_ff == brst_pkg::LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready      = 1'b1;
            ctl.load_delta = req.valid;
            if (req.valid) begin
               if (req.op == brst_pkg::OP_QUERY) begin
                  ctl.mode = brst_pkg::ACC_CLEAR;
                  if (reversed) begin
                     state_in = ST_FINISH;
                  end else begin
                     ptr_in   = lo_addr;
                     hi_in    = hi_clamp;
                     bh_in    = b_high;
                     bptr_in  = b_low + 1'b1;
                     same_in  = (b_low == b_high);
                     last_in  = (b_low == b_high) ? hi_clamp : brst_pkg::bucket_last(b_low);
                     state_in = ST_FRAG_LOW;
                  end
               end else if (in_table) begin
                  ptr_in   = idx_wide[brst_pkg::ADDR_W-1:0];
                  bptr_in  = brst_pkg::bucket_of(idx_wide[brst_pkg::ADDR_W-1:0]);
                  state_in = ST_UPD_READ;
               end
            end
         end
         ST_UPD_READ: begin
            state_in = ST_UPD_ELEM;
         end
         ST_UPD_ELEM: begin
            ctl.mode    = brst_pkg::ACC_UPD_ELEM;
            ctl.elem_we = 1'b1;
            state_in    = ST_UPD_BUCKET;
         end
         ST_UPD_BUCKET: begin
            ctl.mode   = brst_pkg::ACC_UPD_BUCKET;
            ctl.bkt_we = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FRAG_LOW: begin
            pend_in = brst_pkg::ACC_ELEM;
            if (ptr_ff == last_ff) begin
               if (same_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  ptr_in   = brst_pkg::bucket_first(bh_ff);
                  last_in  = hi_ff;
                  state_in = ST_FRAG_HIGH;
               end
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_FRAG_HIGH: begin
            pend_in = brst_pkg::ACC_ELEM;
            if (ptr_ff == last_ff) begin
               state_in = (bptr_ff != bh_ff) ? ST_BUCKETS : ST_DRAIN;
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_BUCKETS: begin
            pend_in = brst_pkg::ACC_BUCKET;
            bptr_in = bptr_next;
            if (bptr_next == bh_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= brst_pkg::ACC_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      hi_ff   <= hi_in;
      bptr_ff <= bptr_in;
      bh_ff   <= bh_in;
      same_ff <= same_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/bucketed_range_sum_table.sv */
// Top level: bucketed range sum table with element and bucket total memories.
//
//   channel   direction  payload                                   transfer
//   req_ch    in         op, index, delta, range_low, range_high   valid & ready
//   rsp_ch    out        range_total                               valid & ready
//
// After reset a clearing pass writes zero to all 1024 elements, one per cycle,
// and no request is taken until the pass is done.
// An update makes one memory read, then one pass each through the shared
// 64-bit adder for the element and for its bucket total. It gives no response.
// A query adds the elements of the low and high end fragments one at a time,
// then the whole bucket totals between them; the single memory read port
// and the shared adder force this. A reversed range skips the walk and gives zero.
// The response register lets a request be taken while a response stalls.
module bucketed_range_sum_table (
   input  logic         clock,
   input  logic         reset,
   brst_req_if.sink     req_ch,
   brst_rsp_if.source   rsp_ch
);

   brst_pkg::ctl_type             ctl;
   logic [brst_pkg::ELEM_W-1:0]   elem_rd, elem_wdata;
   logic [brst_pkg::TOTAL_W-1:0]  bkt_rd, bkt_wdata;
   logic signed [brst_pkg::TOTAL_W-1:0] total;
   logic                          rsp_valid;

   brst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   brst_accum u_accum (
      .clock      (clock),
      .ctl        (ctl),
      .delta      (req_ch.delta),
      .elem_rd    (elem_rd),
      .bkt_rd     (bkt_rd),
      .elem_wdata (elem_wdata),
      .bkt_wdata  (bkt_wdata),
      .total      (total)
   );

   brst_ram #(
      .WIDTH (brst_pkg::ELEM_W),
      .DEPTH (brst_pkg::ARRAY_DEPTH)
   ) u_elem_ram (
      .clock (clock),
      .we    (ctl.elem_we),
      .addr  (ctl.elem_addr),
      .wdata (elem_wdata),
      .rdata (elem_rd)
   );

   brst_ram #(
      .WIDTH (brst_pkg::TOTAL_W),
      .DEPTH (brst_pkg::BUCKET_COUNT)
   ) u_bkt_ram (
      .clock (clock),
      .we    (ctl.bkt_we),
      .addr  (ctl.bkt_addr),
      .wdata (bkt_wdata),
      .rdata (bkt_rd)
   );

   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.range_total = total;

`ifndef NO_ASSERTIONS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while a previous one is in progress");

   a_update_silent: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.op == brst_pkg::OP_ADD && !rsp_ch.valid
      |=> !rsp_ch.valid)
      else $error("update produced a response");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request accepted before clearing pass");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.elem_we || ctl.bkt_we |-> !req_ch.ready)
      else $error("memory write while idle");
`endif

endmodule
